FILE: hw/rtl/n2a_pkg.sv
// Shared types, constants and helpers of the number to ASCII formatter.
package n2a_pkg;

    localparam int BIN_W      = 32;
    localparam int DEC_DIGITS = 10;
    localparam int DIG_W      = DEC_DIGITS * 4;
    localparam int CNT_W      = $clog2(DEC_DIGITS + 1);
    localparam int BIT_CNT_W  = $clog2(BIN_W);

    localparam logic [CNT_W-1:0] HEX_BYTE_DIGITS = CNT_W'(2);
    localparam logic [CNT_W-1:0] HEX_WORD_DIGITS = CNT_W'(8);

    localparam logic [1:0] OP_HEX_BYTE = 2'd0;
    localparam logic [1:0] OP_HEX_WORD = 2'd1;
    localparam logic [1:0] OP_DEC      = 2'd2;

    localparam logic [7:0] ASCII_DIGIT_BASE  = 8'h30;
    localparam logic [7:0] ASCII_LETTER_BASE = 8'h37;
    localparam logic [3:0] NIBBLE_MAX_DIGIT  = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } n2a_state_t;

    typedef struct packed {
        logic load_hex;
        logic hex_byte;
        logic load_dec;
        logic shift;
    } n2a_cmd_t;

    typedef struct packed {
        logic       conv_busy;
        logic [3:0] top_digit;
    } n2a_stat_t;

    function automatic logic [7:0] nib_to_ascii(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib <= NIBBLE_MAX_DIGIT)
        begin
            ch = ASCII_DIGIT_BASE + {4'b0, nib};
        end
        else
        begin
            ch = ASCII_LETTER_BASE + {4'b0, nib};
        end
        return ch;
    endfunction

endpackage

FILE: hw/rtl/n2a_num_if.sv
// Request channel carrying a format code and the number to format.
interface n2a_num_if
    import n2a_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       opcode;
    logic [BIN_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

FILE: hw/rtl/n2a_text_if.sv
// Request channel carrying one ASCII character and its end-of-number marker.
interface n2a_text_if
    import n2a_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

FILE: hw/rtl/number_to_ascii_formatter.sv
// Top level of the number to ASCII formatter.
// Accepts one number with a format code and sends its text one character per output
// request, most significant first, with last_char set on the final one. Format 0 gives
// two hex digits of the low byte, format 1 eight hex digits, format 2 unsigned decimal
// without leading zeros; format 3 is accepted and produces nothing. One number is
// handled at a time: a hex number is accepted and then its characters are sent;
// a decimal number is accepted, its 32 input bits pass through the bit-serial binary to BCD
// converter (one input bit per cycle), the end of conversion is seen, suppressed
// leading zeros are shifted out, the first digit is found and the characters are
// sent. A new number is accepted while the last character still waits in the output
// register.
module number_to_ascii_formatter
    import n2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    n2a_num_if.sink     number,
    n2a_text_if.source  text
);

    n2a_state_t       state_reg;
    n2a_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic [7:0]       char_reg;
    logic             last_reg;
    n2a_cmd_t         cmd;
    n2a_stat_t        stat;
    logic             in_take;
    logic             out_free;
    logic             out_load;
    logic             skip_zero;

    assign number.ready = (state_reg == ST_IDLE);
    assign in_take      = number.valid && number.ready;
    assign out_free     = !out_valid_reg || text.ready;
    assign skip_zero    = (stat.top_digit == 4'd0) && (count_reg > CNT_W'(1));

    n2a_digits u_digits (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .value (number.value),
        .stat  (stat)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    case (number.opcode)
                        OP_HEX_BYTE:
                        begin
                            state_next = ST_EMIT;
                            count_next = HEX_BYTE_DIGITS;
                        end
                        OP_HEX_WORD:
                        begin
                            state_next = ST_EMIT;
                            count_next = HEX_WORD_DIGITS;
                        end
                        OP_DEC:
                        begin
                            state_next = ST_CONV;
                            count_next = CNT_W'(DEC_DIGITS);
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                if (!stat.conv_busy)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (skip_zero)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    cmd.load_hex = (number.opcode == OP_HEX_BYTE) ||
                                   (number.opcode == OP_HEX_WORD);
                    cmd.hex_byte = (number.opcode == OP_HEX_BYTE);
                    cmd.load_dec = (number.opcode == OP_DEC);
                end
            end
            ST_SKIP:
            begin
                cmd.shift = skip_zero;
            end
            ST_EMIT:
            begin
                cmd.shift = out_free;
                out_load  = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (text.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            char_reg <= nib_to_ascii(stat.top_digit);
            last_reg <= (count_reg == CNT_W'(1));
        end
    end

    assign text.valid     = out_valid_reg;
    assign text.text_char = char_reg;
    assign text.last_char = last_reg;

    // The converter only runs while a decimal number is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.conv_busy |-> (state_reg == ST_CONV))
        else $error("BCD converter busy outside conversion");

    // Every character sent is a hex digit or a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        text.valid |-> ((text.text_char >= 8'h30 && text.text_char <= 8'h39) ||
                        (text.text_char >= 8'h41 && text.text_char <= 8'h46)))
        else $error("Output character is not a hex digit");

    // While characters are being sent there is always at least one left.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) || (state_reg == ST_SKIP)) |->
            (count_reg != '0) && (count_reg <= CNT_W'(DEC_DIGITS)))
        else $error("Digit count out of range");

    // Leaving the emit phase coincides with loading the final character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |=> (text.valid && text.last_char))
        else $error("Final character not marked");

endmodule

FILE: hw/rtl/n2a_digits.sv
// Digit shift register with a bit-serial double-dabble binary to BCD converter.
module n2a_digits
    import n2a_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  n2a_cmd_t         cmd,
    input  logic [BIN_W-1:0] value,
    output n2a_stat_t        stat
);

    logic [DIG_W-1:0]     dig_reg;
    logic [DIG_W-1:0]     dig_next;
    logic [BIN_W-1:0]     bin_reg;
    logic [BIN_W-1:0]     bin_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic [DIG_W-1:0]     adjusted;

    // Each BCD digit of five or more gets three added before the next shift.
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (dig_reg[i*4 +: 4] >= 4'd5)
            begin
                adjusted[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adjusted[i*4 +: 4] = dig_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        dig_next     = dig_reg;
        bin_next     = bin_reg;
        bit_cnt_next = bit_cnt_reg;
        busy_next    = busy_reg;
        if (cmd.load_hex)
        begin
            if (cmd.hex_byte)
            begin
                dig_next = {value[7:0], (DIG_W - 8)'(0)};
            end
            else
            begin
                dig_next = {value, (DIG_W - BIN_W)'(0)};
            end
        end
        else if (cmd.load_dec)
        begin
            dig_next     = '0;
            bin_next     = value;
            bit_cnt_next = BIT_CNT_W'(BIN_W - 1);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            dig_next     = {adjusted[DIG_W-2:0], bin_reg[BIN_W-1]};
            bin_next     = {bin_reg[BIN_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - 1'b1;
            if (bit_cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
        else if (cmd.shift)
        begin
            dig_next = {dig_reg[DIG_W-5:0], 4'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg     <= dig_next;
        bin_reg     <= bin_next;
        bit_cnt_reg <= bit_cnt_next;
    end

    assign stat.conv_busy = busy_reg;
    assign stat.top_digit = dig_reg[DIG_W-1 -: 4];

endmodule
